### rtl/hydro_lift_drag_force_defines.svh
// Assertion macros for the lift and drag force block.
// Used by the checker module; the sampling clock and reset come from the including scope.
`ifndef HYDRO_LIFT_DRAG_FORCE_DEFINES_SVH
`define HYDRO_LIFT_DRAG_FORCE_DEFINES_SVH
// Same-cycle implication, disabled while reset is high.
`define HLDF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define HLDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

### rtl/hldf_pkg.sv
// Shared types and constants of the lift and drag force block.
// No dependencies.
package hldf_pkg;

   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;
   // Square root pipeline: one stage per result bit plus the rounding stage.
   localparam int SQ_LAT = ROOT_W + 1;

   localparam logic [2:0] CSR_DENSITY = 3'd0;
   localparam logic [2:0] CSR_LIFT_XY = 3'd1;
   localparam logic [2:0] CSR_LIFT_XZ = 3'd2;
   localparam logic [2:0] CSR_DRAG_X  = 3'd3;
   localparam logic [2:0] CSR_DRAG_Y  = 3'd4;
   localparam logic [2:0] CSR_DRAG_Z  = 3'd5;

   localparam logic [31:0] DENSITY_RESET = 32'd65536000;

   localparam logic signed [32:0] DRAG_OFF_XY = 33'sd7;
   localparam logic signed [32:0] DRAG_OFF_Z  = 33'sd1;

   typedef enum logic [1:0] {
      SGN_ZERO,
      SGN_POS,
      SGN_NEG
   } sign_type;

   typedef struct packed {
      logic [31:0] rho;
      logic [31:0] c_lxy;
      logic [31:0] c_lxz;
      logic [31:0] c_dx;
      logic [31:0] c_dy;
      logic [31:0] c_dz;
   } cfg_type;

   typedef struct packed {
      logic [3:0]        lift_neg;
      sign_type [2:0]    drag_sgn;
   } flag_type;

   typedef struct packed {
      logic [31:0] mag_u;
      logic [31:0] mag_v;
      logic [31:0] mag_w;
      flag_type    flags;
   } queue_item_type;

endpackage

### rtl/hldf_queue.sv
// Short item queue between the front and the back pipelines.
// Depends on hldf_pkg for the queued item type.
module hldf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  hldf_pkg::queue_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output hldf_pkg::queue_item_type out_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   hldf_pkg::queue_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             push, pop;

   assign in_ready  = (cnt_ff != CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/hldf_front.sv
// Front pipeline: accepts items, rotates the flow into the body frame, forms the
// relative velocity and classifies its signs. Depends on hldf_pkg.
module hldf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [255:0]             req_tdata,
   output logic                     q_valid,
   input  logic                     q_ready,
   output hldf_pkg::queue_item_type q_item
);

   localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

   function automatic logic signed [34:0] ex35(input logic signed [31:0] a);
      ex35 = {{3{a[31]}}, a};
   endfunction

   function automatic logic signed [65:0] ex66(input logic signed [63:0] a);
      ex66 = {{2{a[63]}}, a};
   endfunction

   function automatic logic signed [31:0] clamp_q30(input logic signed [34:0] v);
      if (v > ONE_Q30) begin
         clamp_q30 = 32'sh4000_0000;
      end else if (v < -ONE_Q30) begin
         clamp_q30 = -32'sh4000_0000;
      end else begin
         clamp_q30 = v[31:0];
      end
   endfunction

   function automatic hldf_pkg::sign_type drag_class(input logic signed [31:0] a,
                                                     input logic signed [32:0] off);
      logic signed [32:0] t;
      t = {a[31], a} + off;
      if (t > 0) begin
         drag_class = hldf_pkg::SGN_NEG;
      end else if (t < 0) begin
         drag_class = hldf_pkg::SGN_POS;
      end else begin
         drag_class = hldf_pkg::SGN_ZERO;
      end
   endfunction

   logic fe;
   logic [6:0] fv_ff;

   logic signed [15:0] qw, qx, qy, qz;
   logic signed [31:0] fl_in [3];
   logic signed [31:0] bv_in [3];

   logic signed [31:0] bb_ff, cc_ff, dd_ff, bc_ff, ad_ff, bd_ff, ac_ff, cd_ff, ab_ff;
   logic signed [31:0] fl_ff [2][3];
   logic signed [31:0] bv_ff [5][3];
   logic signed [31:0] m_ff [3][3];
   logic signed [63:0] p_ff [3][3];
   logic signed [65:0] acc_ff [3];
   logic signed [36:0] rnd_ff [3];
   logic signed [31:0] rel_ff [3];
   hldf_pkg::queue_item_type item_ff;

   logic signed [36:0] rnd_in [3];
   logic signed [31:0] rel_in [3];
   hldf_pkg::queue_item_type item_in;

   assign fe         = !fv_ff[6] || q_ready;
   assign req_tready = fe;
   assign q_valid    = fv_ff[6];
   assign q_item     = item_ff;

   assign qw = req_tdata[207:192];
   assign qx = req_tdata[223:208];
   assign qy = req_tdata[239:224];
   assign qz = req_tdata[255:240];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fl_in[i] = req_tdata[32*i +: 32];
         bv_in[i] = req_tdata[96 + 32*i +: 32];
      end
   end

   // Round to Q16.16 half away from zero, then subtract from the body velocity.
   always_comb begin
      logic [65:0] mag;
      logic [65:0] sum;
      logic signed [37:0] dif;
      for (int i = 0; i < 3; i++) begin
         mag = acc_ff[i][65] ? 66'(-acc_ff[i]) : 66'(acc_ff[i]);
         sum = mag + (66'd1 << 29);
         rnd_in[i] = acc_ff[i][65] ? -$signed({1'b0, sum[65:30]})
                                   : $signed({1'b0, sum[65:30]});
         dif = {{6{bv_ff[4][i][31]}}, bv_ff[4][i]} - {rnd_ff[i][36], rnd_ff[i]};
         if (dif > 38'sd2147483647) begin
            rel_in[i] = 32'sh7FFF_FFFF;
         end else if (dif < -38'sd2147483648) begin
            rel_in[i] = 32'sh8000_0000;
         end else begin
            rel_in[i] = dif[31:0];
         end
      end
   end

   always_comb begin
      logic signed [31:0] u, v, w;
      logic same_xy, flip_xz;
      u = rel_ff[0];
      v = rel_ff[1];
      w = rel_ff[2];
      same_xy = (u > 0 && v > 0) || (u < 0 && v < 0);
      flip_xz = (u > 0 && w < 0) || (u < 0 && w > 0);
      item_in.mag_u = (u < 0) ? 32'(-u) : 32'(u);
      item_in.mag_v = (v < 0) ? 32'(-v) : 32'(v);
      item_in.mag_w = (w < 0) ? 32'(-w) : 32'(w);
      // The lift directions are flipped so that their x part follows u.
      item_in.flags.lift_neg[0] = same_xy ? (v < 0) : (v > 0);
      item_in.flags.lift_neg[1] = same_xy ? (u > 0) : (u < 0);
      item_in.flags.lift_neg[2] = flip_xz ? (w > 0) : (w < 0);
      item_in.flags.lift_neg[3] = flip_xz ? (u < 0) : (u > 0);
      item_in.flags.drag_sgn[0] = drag_class(u, hldf_pkg::DRAG_OFF_XY);
      item_in.flags.drag_sgn[1] = drag_class(v, hldf_pkg::DRAG_OFF_XY);
      item_in.flags.drag_sgn[2] = drag_class(w, hldf_pkg::DRAG_OFF_Z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (fe) begin
         fv_ff <= {fv_ff[5:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         bb_ff <= qx * qx;
         cc_ff <= qy * qy;
         dd_ff <= qz * qz;
         bc_ff <= qx * qy;
         ad_ff <= qw * qz;
         bd_ff <= qx * qz;
         ac_ff <= qw * qy;
         cd_ff <= qy * qz;
         ab_ff <= qw * qx;
         fl_ff[0] <= fl_in;
         fl_ff[1] <= fl_ff[0];
         bv_ff[0] <= bv_in;
         for (int s = 1; s < 5; s++) begin
            bv_ff[s] <= bv_ff[s-1];
         end

         // Transposed rotation matrix in Q2.30, each entry clamped to [-1, 1].
         m_ff[0][0] <= clamp_q30(ONE_Q30 - ((ex35(cc_ff) + ex35(dd_ff)) <<< 1));
         m_ff[0][1] <= clamp_q30((ex35(bc_ff) + ex35(ad_ff)) <<< 1);
         m_ff[0][2] <= clamp_q30((ex35(bd_ff) - ex35(ac_ff)) <<< 1);
         m_ff[1][0] <= clamp_q30((ex35(bc_ff) - ex35(ad_ff)) <<< 1);
         m_ff[1][1] <= clamp_q30(ONE_Q30 - ((ex35(bb_ff) + ex35(dd_ff)) <<< 1));
         m_ff[1][2] <= clamp_q30((ex35(cd_ff) + ex35(ab_ff)) <<< 1);
         m_ff[2][0] <= clamp_q30((ex35(bd_ff) + ex35(ac_ff)) <<< 1);
         m_ff[2][1] <= clamp_q30((ex35(cd_ff) - ex35(ab_ff)) <<< 1);
         m_ff[2][2] <= clamp_q30(ONE_Q30 - ((ex35(bb_ff) + ex35(cc_ff)) <<< 1));

         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[i][j] <= m_ff[i][j] * fl_ff[1][j];
            end
            acc_ff[i] <= ex66(p_ff[i][0]) + ex66(p_ff[i][1]) + ex66(p_ff[i][2]);
         end
         rnd_ff  <= rnd_in;
         rel_ff  <= rel_in;
         item_ff <= item_in;
      end
   end

endmodule

### rtl/hldf_sqrt.sv
// Pipelined integer square root rounded to nearest, one result bit per stage.
// Depends on hldf_pkg for the widths.
module hldf_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [hldf_pkg::RAD_W-1:0]   rad,
   output logic [hldf_pkg::ROOT_W-1:0]  root
);

   localparam int RW = hldf_pkg::RAD_W;
   localparam int QW = hldf_pkg::ROOT_W;

   logic [RW-1:0] x_ff    [QW];
   logic [QW+1:0] rem_ff  [QW];
   logic [QW-1:0] root_ff [QW];
   logic [QW-1:0] out_ff;

   logic [RW-1:0] x_pv    [QW];
   logic [QW+1:0] rem_pv  [QW];
   logic [QW-1:0] root_pv [QW];
   logic [QW+3:0] cur     [QW];
   logic [QW+3:0] dif     [QW];

   always_comb begin
      for (int i = 0; i < QW; i++) begin
         if (i == 0) begin
            x_pv[i]    = rad;
            rem_pv[i]  = '0;
            root_pv[i] = '0;
         end else begin
            x_pv[i]    = x_ff[i-1];
            rem_pv[i]  = rem_ff[i-1];
            root_pv[i] = root_ff[i-1];
         end
         cur[i] = {rem_pv[i], x_pv[i][RW-1 -: 2]};
         dif[i] = cur[i] - {2'b00, root_pv[i], 2'b01};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QW; i++) begin
            x_ff[i] <= {x_pv[i][RW-3:0], 2'b00};
            if (!dif[i][QW+3]) begin
               rem_ff[i]  <= dif[i][QW+1:0];
               root_ff[i] <= {root_pv[i][QW-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= cur[i][QW+1:0];
               root_ff[i] <= {root_pv[i][QW-2:0], 1'b0};
            end
         end
         // A remainder above the root means the exact value lies past the half step.
         out_ff <= root_ff[QW-1] + QW'(rem_ff[QW-1] > {2'b00, root_ff[QW-1]});
      end
   end

   assign root = out_ff;

endmodule

### rtl/hldf_back.sv
// Back pipeline: squares, plane lengths, force scaling with saturation and the
// output register. Depends on hldf_pkg and hldf_sqrt.
module hldf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  hldf_pkg::cfg_type        cfg,
   input  logic                     q_valid,
   output logic                     q_ready,
   input  hldf_pkg::queue_item_type q_item,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [287:0]             rsp_tdata
);

   localparam int LAT = hldf_pkg::SQ_LAT;
   localparam int NSTG = LAT + 6;
   localparam int NTERM = 7;
   localparam int KSEL [NTERM] = '{0, 0, 1, 1, 2, 3, 4};
   localparam logic signed [48:0] FMAX = 49'sd140737488355327;

   typedef struct packed {
      hldf_pkg::queue_item_type item;
      logic [63:0] uu;
      logic [63:0] vv;
      logic [63:0] ww;
   } sq_type;

   // k*x / 2^49 rounded half up, saturated to 2^47-1, from four partial products.
   function automatic logic [46:0] scale_sat(input logic [63:0] p0, input logic [63:0] p1,
                                             input logic [63:0] p2, input logic [63:0] p3);
      logic [127:0] s;
      s = {p3, 64'd0} + {32'd0, p1, 32'd0} + {32'd0, p2, 32'd0} + {64'd0, p0}
          + (128'd1 << 48);
      if (s[127:96] != '0) begin
         scale_sat = '1;
      end else begin
         scale_sat = s[95:49];
      end
   endfunction

   logic be;
   logic [NSTG-1:0] vld_ff;
   logic [63:0] k_ff [5];

   sq_type b1_ff, b2_ff;
   sq_type dly_ff [LAT];
   logic [63:0] sxy, sxz;
   logic [hldf_pkg::ROOT_W-1:0] rxy, rxz;

   logic [63:0] x3_ff [NTERM];
   logic [63:0] pp_ff [NTERM][4];
   logic [46:0] f5_ff [NTERM];
   hldf_pkg::flag_type fl3_ff, fl4_ff, fl5_ff;
   logic signed [47:0] out_ff [6];

   logic signed [47:0] t_in [NTERM];
   logic signed [48:0] lx_sum;
   logic signed [47:0] out_in [6];

   assign be      = !vld_ff[NSTG-1] || rsp_tready;
   assign q_ready = be;
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {out_ff[5], out_ff[4], out_ff[3], out_ff[2], out_ff[1], out_ff[0]};

   assign sxy = b2_ff.uu + b2_ff.vv;
   assign sxz = b2_ff.uu + b2_ff.ww;

   hldf_sqrt u_sqrt_xy (.clock(clock), .en(be), .rad(sxy), .root(rxy));
   hldf_sqrt u_sqrt_xz (.clock(clock), .en(be), .rad(sxz), .root(rxz));

   always_comb begin
      for (int t = 0; t < 4; t++) begin
         t_in[t] = fl5_ff.lift_neg[t] ? -$signed({1'b0, f5_ff[t]})
                                      : $signed({1'b0, f5_ff[t]});
      end
      for (int d = 0; d < 3; d++) begin
         unique case (fl5_ff.drag_sgn[d])
            hldf_pkg::SGN_NEG:  t_in[d+4] = -$signed({1'b0, f5_ff[d+4]});
            hldf_pkg::SGN_POS:  t_in[d+4] = $signed({1'b0, f5_ff[d+4]});
            default:            t_in[d+4] = '0;
         endcase
      end
      lx_sum = {t_in[0][47], t_in[0]} + {t_in[2][47], t_in[2]};
      if (lx_sum > FMAX) begin
         out_in[0] = FMAX[47:0];
      end else if (lx_sum < -FMAX) begin
         out_in[0] = -FMAX[47:0];
      end else begin
         out_in[0] = lx_sum[47:0];
      end
      out_in[1] = t_in[1];
      out_in[2] = t_in[3];
      out_in[3] = t_in[4];
      out_in[4] = t_in[5];
      out_in[5] = t_in[6];
   end

   always_ff @(posedge clock) begin
      k_ff[0] <= cfg.rho * cfg.c_lxy;
      k_ff[1] <= cfg.rho * cfg.c_lxz;
      k_ff[2] <= cfg.rho * cfg.c_dx;
      k_ff[3] <= cfg.rho * cfg.c_dy;
      k_ff[4] <= cfg.rho * cfg.c_dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (be) begin
         vld_ff <= {vld_ff[NSTG-2:0], q_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         b1_ff.item <= q_item;
         b1_ff.uu   <= q_item.mag_u * q_item.mag_u;
         b1_ff.vv   <= q_item.mag_v * q_item.mag_v;
         b1_ff.ww   <= q_item.mag_w * q_item.mag_w;
         b2_ff      <= b1_ff;
         dly_ff[0]  <= b2_ff;
         for (int s = 1; s < LAT; s++) begin
            dly_ff[s] <= dly_ff[s-1];
         end

         x3_ff[0] <= dly_ff[LAT-1].item.mag_v * rxy;
         x3_ff[1] <= dly_ff[LAT-1].item.mag_u * rxy;
         x3_ff[2] <= dly_ff[LAT-1].item.mag_w * rxz;
         x3_ff[3] <= dly_ff[LAT-1].item.mag_u * rxz;
         x3_ff[4] <= dly_ff[LAT-1].uu;
         x3_ff[5] <= dly_ff[LAT-1].vv;
         x3_ff[6] <= dly_ff[LAT-1].ww;
         fl3_ff   <= dly_ff[LAT-1].item.flags;

         for (int t = 0; t < NTERM; t++) begin
            pp_ff[t][0] <= k_ff[KSEL[t]][31:0]  * x3_ff[t][31:0];
            pp_ff[t][1] <= k_ff[KSEL[t]][31:0]  * x3_ff[t][63:32];
            pp_ff[t][2] <= k_ff[KSEL[t]][63:32] * x3_ff[t][31:0];
            pp_ff[t][3] <= k_ff[KSEL[t]][63:32] * x3_ff[t][63:32];
            f5_ff[t] <= scale_sat(pp_ff[t][0], pp_ff[t][1], pp_ff[t][2], pp_ff[t][3]);
         end
         fl4_ff <= fl3_ff;
         fl5_ff <= fl4_ff;
         out_ff <= out_in;
      end
   end

endmodule

### rtl/hydro_lift_drag_force.sv
// Top level of the quadratic lift and drag force block.
// Depends on hldf_pkg, hldf_front, hldf_queue and hldf_back.
//
// Usage:
//   req_* carries one item per body: world flow velocity, body velocity and the
//   orientation quaternion. rsp_* returns one item with three lift and three
//   drag force components in saturated Q32.16.
//   csr_* writes the density and coefficient registers, one per cycle while
//   csr_we is high; indexes past the last register are ignored.
// Throughput: one item per cycle unless stalled; every stage is pipelined, the two square
//   root units give one result bit per stage.
// Path: with no stall, an item passes 7 front stages, one queue entry and 39
//   back stages including the 33-stage square root; the first front stage
//   loads at the accepting edge.
// Reset: clears all valid state and sets the density to 1000.0 and all
//   coefficients to zero.
// Stall: when rsp_tready is low with rsp_tvalid high the back pipeline holds; the front keeps
//   accepting until the queue between the two fills, then req_tready drops.
module hydro_lift_drag_force #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // flow_vx, flow_vy, flow_vz, body_vx, body_vy, body_vz, quat_w, quat_x, quat_y, quat_z
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // lift_x, lift_y, lift_z, drag_x, drag_y, drag_z
   output logic [287:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   hldf_pkg::cfg_type        cfg_ff;
   logic                     q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   hldf_pkg::queue_item_type q_in_item, q_out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{hldf_pkg::DENSITY_RESET, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      end else if (csr_we) begin
         unique case (csr_index)
            hldf_pkg::CSR_DENSITY: cfg_ff.rho   <= csr_wdata;
            hldf_pkg::CSR_LIFT_XY: cfg_ff.c_lxy <= csr_wdata;
            hldf_pkg::CSR_LIFT_XZ: cfg_ff.c_lxz <= csr_wdata;
            hldf_pkg::CSR_DRAG_X:  cfg_ff.c_dx  <= csr_wdata;
            hldf_pkg::CSR_DRAG_Y:  cfg_ff.c_dy  <= csr_wdata;
            hldf_pkg::CSR_DRAG_Z:  cfg_ff.c_dz  <= csr_wdata;
            default: ;
         endcase
      end
   end

   hldf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_in_valid),
      .q_ready    (q_in_ready),
      .q_item     (q_in_item)
   );

   hldf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_item   (q_in_item),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_item  (q_out_item)
   );

   hldf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_out_valid),
      .q_ready    (q_out_ready),
      .q_item     (q_out_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/hldf_checker.sv
// Port-level checker for the lift and drag force block, bound to the top level.
// Depends on hydro_lift_drag_force_defines.svh.
`include "hydro_lift_drag_force_defines.svh"

module hldf_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [287:0] rsp_tdata
);

   logic       rsp_stall;
   logic [5:0] at_min;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // Each force field is saturated symmetrically, so the most negative code never shows.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         at_min[i] = (rsp_tdata[48*i +: 48] == {1'b1, 47'd0});
      end
   end

   `HLDF_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled item changed")
   `HLDF_ASSERT_NOW(a_rsp_after_reset, $past(reset), !rsp_tvalid, "item valid after reset")
   `HLDF_ASSERT_NOW(a_no_min_force, rsp_tvalid, at_min == '0, "force at negative limit")

endmodule

bind hydro_lift_drag_force hldf_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
